>>> hw/rtl/pidr_pkg.sv
// pidr_pkg: shared types, register indexes and saturation helpers
// for the pi drive regulator. No dependencies.
package pidr_pkg;

  typedef logic signed [31:0] data_t;

  localparam data_t DATA_MAX = 32'sh7FFF_FFFF;
  localparam data_t DATA_MIN = 32'sh8000_0000;

  localparam int unsigned REG_IDX_W = 3;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_FLAGS     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GOAL      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INT_GAIN  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STEP_LIM  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_MIN = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_MAX = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD    = 3'd7;

  // saturate a 33-bit sum or difference to 32 bits
  function automatic data_t sat33(input logic signed [32:0] v);
    data_t r;
    if (v[32] != v[31]) begin
      r = v[32] ? DATA_MIN : DATA_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/pidr_mul.sv
// pidr_mul: shared 32x32 signed multiplier with registered product and
// fixed-point scaling (floor shift, saturate). Uses pidr_pkg.
module pidr_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  pidr_pkg::data_t a,
  input  pidr_pkg::data_t b,
  output pidr_pkg::data_t fx
);
  import pidr_pkg::*;

  logic signed [63:0] prod;
  logic signed [63:0] scaled;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // arithmetic shift rounds toward minus infinity
  assign scaled = prod >>> FRAC_BITS;

  always_comb begin
    if (scaled[63:31] == {33{1'b0}} || scaled[63:31] == {33{1'b1}}) begin
      fx = scaled[31:0];
    end else begin
      fx = scaled[63] ? DATA_MIN : DATA_MAX;
    end
  end

endmodule

>>> hw/rtl/pidr_div.sv
// pidr_div: restoring serial divider, one quotient bit per cycle.
// Unsigned dividend of DIV_W bits over a 31-bit divisor. Uses pidr_pkg.
module pidr_div #(
  parameter int DIV_W = 47
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [30:0]      divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);
  import pidr_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [30:0]      rem;
  logic [30:0]      dvs;
  logic [DIV_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [31:0]      trial;
  logic             ge;
  data_t            diff;

  assign trial    = {rem, quo[DIV_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(DIV_W);
        rem <= '0;
        dvs <= divisor;
        quo <= dividend;
      end else if (run) begin
        rem <= ge ? diff[30:0] : trial[30:0];
        quo <= {quo[DIV_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/pi_drive_regulator.sv
// pi_drive_regulator: top level, request handshakes, configuration registers
// and the sequencer. Uses pidr_pkg, pidr_mul and pidr_div.
//
// PI regulator with anti-windup that sets a drive value from a measured
// current. One request is worked at a time: s_tready is high only while the
// sequencer is idle, and each request yields exactly one result on m_*. A
// reset request and a tick without an update go from prep straight to done;
// an update in total mode makes four passes through the one shared
// multiplier. In average mode the serial divider runs first; with zero area
// the divider is skipped. Results wait in an output register, so the next
// request is taken while a result is still held.
module pi_drive_regulator #(
  parameter int FRAC_BITS   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [pidr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  // request side
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // net_current[31:0], face_area[62:32], time_step[93:63],
  // patch_average[125:94], reset_drive[157:126], zero pad
  input  logic [159:0]                   s_tdata,
  // action[0]
  input  logic                           s_tuser,
  // result side
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // drive_value[31:0], error_value[63:32], integral_value[95:64]
  output logic [95:0]                    m_tdata,
  // did_update[0]
  output logic                           m_tuser
);
  import pidr_pkg::*;

  localparam int DIV_W = 31 + FRAC_BITS;
  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [30:0] STEP_RST = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV, S_GA, S_ERR, S_INT, S_INTADD,
    S_KP, S_KPR, S_KI, S_KIR, S_STEP, S_CLAMP, S_DONE
  } state_t;

  // configuration
  logic [1:0]  control_flags;
  data_t       goal_density;
  data_t       prop_gain;
  data_t       integral_gain;
  logic [30:0] step_limit;
  data_t       drive_min;
  data_t       drive_max;
  logic [15:0] update_period;

  // controller state
  data_t                  drive;
  data_t                  error_integral;
  logic                   initialized;
  logic                   never_updated;
  logic [COUNT_WIDTH-1:0] ticks_since_update;

  // request fields
  logic        action;
  data_t       net_current;
  logic [30:0] face_area;
  logic [30:0] time_step;
  data_t       patch_average;
  data_t       reset_drive;

  // work registers
  state_t      state;
  logic        upd;
  data_t       err;
  data_t       avg;
  data_t       kp_term;
  data_t       du;

  // shared units
  data_t             mul_a;
  data_t             mul_b;
  data_t             mul_fx;
  logic              div_start;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;

  // combinational helpers
  data_t                  err_next;
  data_t                  drive_pick;
  data_t                  drive_lim;
  data_t                  sub_clamped;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [15:0]            period;
  logic                   upd_next;
  logic                   freeze;
  data_t                  neg_limit;
  logic [30:0]            cur_abs;

  function automatic data_t clamp(input data_t x, input data_t lo, input data_t hi);
    data_t y;
    y = (x > hi) ? hi : x;
    y = (y < lo) ? lo : y;
    return y;
  endfunction

  assign s_tready = (state == S_IDLE);

  pidr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .fx  (mul_fx)
  );

  pidr_div #(.DIV_W(DIV_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({cur_abs, {FRAC_BITS{1'b0}}}),
    .divisor  (face_area),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    unique case (state)
      S_INT: begin
        mul_a = err;
        mul_b = {1'b0, time_step};
      end
      S_KP: begin
        mul_a = prop_gain;
        mul_b = err;
      end
      S_KI: begin
        mul_a = integral_gain;
        mul_b = error_integral;
      end
      default: begin
        mul_a = goal_density;
        mul_b = {1'b0, face_area};
      end
    endcase
  end

  always_comb begin
    if (net_current == DATA_MIN) begin
      cur_abs = DATA_MAX[30:0];
    end else if (net_current < 0) begin
      cur_abs = 31'(-net_current);
    end else begin
      cur_abs = net_current[30:0];
    end
    period     = (update_period == 16'd0) ? 16'd1 : update_period;
    cnt_inc    = (ticks_since_update == CNT_MAX) ? ticks_since_update
                                                 : ticks_since_update + 1'b1;
    upd_next   = never_updated || (CMP_W'(cnt_inc) >= CMP_W'(period)) ||
                 (cnt_inc == CNT_MAX);
    if (action) begin
      drive_pick = reset_drive;
    end else if (control_flags[1] && !initialized) begin
      drive_pick = patch_average;
    end else begin
      drive_pick = drive;
    end
    drive_lim  = clamp(drive_pick, drive_min, drive_max);
    if (control_flags[0]) begin
      err_next = sat33({goal_density[31], goal_density} - {avg[31], avg});
    end else begin
      err_next = sat33({mul_fx[31], mul_fx} - {2'b00, cur_abs});
    end
    freeze      = (drive <= drive_min && err < 0) || (drive >= drive_max && err > 0);
    neg_limit   = -$signed({1'b0, step_limit});
    sub_clamped = sat33({drive[31], drive} - {du[31], du});
    div_start   = (state == S_PREP) && !action && upd_next && control_flags[0] &&
                  (face_area != 31'd0);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      control_flags <= 2'd2;
      goal_density  <= '0;
      prop_gain     <= '0;
      integral_gain <= '0;
      step_limit    <= STEP_RST;
      drive_min     <= DATA_MIN;
      drive_max     <= DATA_MAX;
      update_period <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FLAGS:     control_flags <= cfg_data[1:0];
        REG_GOAL:      goal_density  <= cfg_data;
        REG_PROP_GAIN: prop_gain     <= cfg_data;
        REG_INT_GAIN:  integral_gain <= cfg_data;
        REG_STEP_LIM:  step_limit    <= cfg_data[30:0];
        REG_DRIVE_MIN: drive_min     <= cfg_data;
        REG_DRIVE_MAX: drive_max     <= cfg_data;
        REG_PERIOD:    update_period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      drive              <= '0;
      error_integral     <= '0;
      initialized        <= 1'b0;
      never_updated      <= 1'b1;
      ticks_since_update <= '0;
      m_tvalid           <= 1'b0;
    end else begin
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            action        <= s_tuser;
            net_current   <= s_tdata[31:0];
            face_area     <= s_tdata[62:32];
            time_step     <= s_tdata[93:63];
            patch_average <= s_tdata[125:94];
            reset_drive   <= s_tdata[157:126];
            state         <= S_PREP;
          end
        end
        S_PREP: begin
          drive <= drive_lim;
          err   <= '0;
          avg   <= '0;
          if (action) begin
            error_integral     <= '0;
            initialized        <= 1'b0;
            never_updated      <= 1'b1;
            ticks_since_update <= '0;
            upd                <= 1'b0;
            state              <= S_DONE;
          end else begin
            upd <= upd_next;
            if (control_flags[1]) begin
              initialized <= 1'b1;
            end
            if (upd_next) begin
              never_updated      <= 1'b0;
              ticks_since_update <= '0;
              if (!control_flags[0]) begin
                state <= S_GA;
              end else if (face_area != 31'd0) begin
                state <= S_DIV;
              end else begin
                state <= S_ERR;
              end
            end else begin
              ticks_since_update <= cnt_inc;
              state              <= S_DONE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_q[DIV_W-1:31] != '0) begin
              avg <= DATA_MAX;
            end else begin
              avg <= {1'b0, div_q[30:0]};
            end
            state <= S_ERR;
          end
        end
        S_GA: begin
          state <= S_ERR;
        end
        S_ERR: begin
          err <= err_next;
          // zero area: error only, no control action
          state <= (face_area == 31'd0) ? S_DONE : S_INT;
        end
        S_INT: begin
          state <= S_INTADD;
        end
        S_INTADD: begin
          // anti-windup: hold the integral while pushing into a limit
          if (!freeze) begin
            error_integral <= sat33({error_integral[31], error_integral} +
                                    {mul_fx[31], mul_fx});
          end
          state <= S_KP;
        end
        S_KP: begin
          state <= S_KPR;
        end
        S_KPR: begin
          kp_term <= mul_fx;
          state   <= S_KI;
        end
        S_KI: begin
          state <= S_KIR;
        end
        S_KIR: begin
          du    <= sat33({kp_term[31], kp_term} + {mul_fx[31], mul_fx});
          state <= S_STEP;
        end
        S_STEP: begin
          if (du > $signed({1'b0, step_limit})) begin
            du <= {1'b0, step_limit};
          end else if (du < neg_limit) begin
            du <= neg_limit;
          end
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          drive <= clamp(sub_clamped, drive_min, drive_max);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {error_integral, err, drive};
            m_tuser  <= upd;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/pi_drive_regulator_tb.sv
// pi_drive_regulator_tb: self-checking bench for the pi drive regulator, with a
// directed table and then random requests, with random stalls on both streams in two of three phases.
// Depends on pidr_pkg and pi_drive_regulator; predicts every result in-bench.
module pi_drive_regulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pidr_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam data_t ONE      = 32'sh0001_0000;

  typedef enum logic {ACT_TICK = 1'b0, ACT_RESET = 1'b1} action_e;
  typedef enum logic {ROW_REQ, ROW_REG} row_kind_e;

  typedef struct {
    action_e     act;
    data_t       cur;
    logic [30:0] area;
    logic [30:0] dt;
    data_t       patch;
    data_t       rdrv;
  } tick_t;

  typedef struct {
    data_t drv;
    logic  upd;
    data_t err;
    data_t integ;
  } result_t;

  typedef struct {
    row_kind_e                kind;
    logic [REG_IDX_W-1:0]     idx;
    logic [31:0]              val;
    tick_t                    req;
    bit                       known;
    result_t                  want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [159:0]         s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [95:0]          m_tdata;
  logic                 m_tuser;

  pi_drive_regulator #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // register copies
  logic [1:0]  flags_q;
  data_t       goal_q, kp_q, ki_q, dmin_q, dmax_q;
  logic [30:0] lim_q;
  logic [15:0] period_q;
  // regulator state copies
  data_t       drv_q, integ_q;
  bit          init_done, fresh;
  logic [15:0] tick_cnt;

  result_t pending_results[$];
  row_t    stim_table[$];
  int      n_err = 0;
  int      n_req = 0;
  int      n_upd = 0;
  int      n_settings = 0;
  int      cycle_cnt = 0;
  int      send_idle = 0;
  int      recv_idle = 0;
  int      stall_left = 0;

  function automatic data_t sat_word(input longint v);
    data_t r;
    if (v > longint'(DATA_MAX)) r = DATA_MAX;
    else if (v < longint'(DATA_MIN)) r = DATA_MIN;
    else r = data_t'(v);
    return r;
  endfunction

  // exact product, floor shift, saturate
  function automatic longint q_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return longint'(sat_word(p >>> FRAC_BITS));
  endfunction

  function automatic data_t clamp_drv(input data_t u);
    data_t r;
    r = u;
    if (r > dmax_q) r = dmax_q;
    if (r < dmin_q) r = dmin_q;
    return r;
  endfunction

  function automatic void regs_to_reset();
    flags_q   = 2'd2;
    goal_q    = '0;
    kp_q      = '0;
    ki_q      = '0;
    lim_q     = 31'd6554;
    dmin_q    = DATA_MIN;
    dmax_q    = DATA_MAX;
    period_q  = 16'd1;
    drv_q     = '0;
    integ_q   = '0;
    init_done = 0;
    fresh     = 1;
    tick_cnt  = '0;
  endfunction

  function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    case (idx)
      REG_FLAGS:     flags_q  = val[1:0];
      REG_GOAL:      goal_q   = val;
      REG_PROP_GAIN: kp_q     = val;
      REG_INT_GAIN:  ki_q     = val;
      REG_STEP_LIM:  lim_q    = val[30:0];
      REG_DRIVE_MIN: dmin_q   = val;
      REG_DRIVE_MAX: dmax_q   = val;
      REG_PERIOD:    period_q = val[15:0];
      default: ;
    endcase
  endfunction

  // one regulator step on the state copies
  function automatic result_t regulate_step(input tick_t t);
    result_t     r;
    logic [15:0] period, cnt;
    bit          upd;
    longint      cur, area, dt, err, avg, du, lim;
    period = (period_q == 0) ? 16'd1 : period_q;
    err    = 0;
    drv_q  = clamp_drv(drv_q);
    if (t.act == ACT_RESET) begin
      drv_q     = clamp_drv(t.rdrv);
      integ_q   = '0;
      init_done = 0;
      fresh     = 1;
      tick_cnt  = '0;
      r.drv = drv_q; r.upd = 1'b0; r.err = '0; r.integ = integ_q;
      return r;
    end
    cnt = tick_cnt;
    if (cnt != 16'hFFFF) cnt = cnt + 16'd1;
    upd = fresh || (cnt >= period) || (cnt == 16'hFFFF);
    if (upd) begin
      fresh    = 0;
      tick_cnt = '0;
    end else begin
      tick_cnt = cnt;
    end
    if (flags_q[1] && !init_done) begin
      drv_q     = clamp_drv(t.patch);
      init_done = 1;
    end
    if (upd) begin
      cur  = longint'(t.cur);
      if (cur < 0) cur = longint'(sat_word(-cur));
      area = longint'(t.area);
      dt   = longint'(t.dt);
      if (!flags_q[0]) begin
        err = longint'(sat_word(q_mul(goal_q, area) - cur));
      end else begin
        avg = 0;
        if (area > 0) avg = longint'(sat_word((cur << FRAC_BITS) / area));
        err = longint'(sat_word(longint'(goal_q) - avg));
      end
      if (area > 0) begin
        // anti-windup: hold the integral while pinned and pushing outward
        if (!((drv_q <= dmin_q && err < 0) || (drv_q >= dmax_q && err > 0)))
          integ_q = sat_word(longint'(integ_q) + q_mul(err, dt));
        du  = longint'(sat_word(q_mul(kp_q, err) + q_mul(ki_q, integ_q)));
        lim = longint'(lim_q);
        if (du > lim) du = lim;
        if (du < -lim) du = -lim;
        drv_q = clamp_drv(sat_word(longint'(drv_q) - du));
      end
    end
    r.drv = drv_q; r.upd = upd; r.err = data_t'(err); r.integ = integ_q;
    return r;
  endfunction

  function automatic tick_t mk(input action_e act, input data_t cur, input logic [30:0] area,
                               input logic [30:0] dt, input data_t patch, input data_t rdrv);
    tick_t t;
    t.act = act; t.cur = cur; t.area = area; t.dt = dt; t.patch = patch; t.rdrv = rdrv;
    return t;
  endfunction

  function automatic result_t res(input data_t drv, input logic upd, input data_t err,
                                  input data_t integ);
    result_t r;
    r.drv = drv; r.upd = upd; r.err = err; r.integ = integ;
    return r;
  endfunction

  function automatic void add_req(input tick_t t);
    row_t r;
    r.kind = ROW_REQ; r.req = t; r.known = 0;
    stim_table.push_back(r);
  endfunction

  function automatic void add_known(input tick_t t, input result_t w);
    row_t r;
    r.kind = ROW_REQ; r.req = t; r.known = 1; r.want = w;
    stim_table.push_back(r);
  endfunction

  function automatic void add_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    row_t r;
    r.kind = ROW_REG; r.idx = idx; r.val = val;
    stim_table.push_back(r);
  endfunction

  function automatic data_t rnd_val(input int span);
    int    sel;
    data_t v;
    sel = $urandom_range(99);
    if (sel < 10) v = $urandom;
    else if (sel < 13) v = DATA_MAX;
    else if (sel < 16) v = DATA_MIN;
    else if (sel < 19) v = '0;
    else begin
      v = $urandom_range((1 << span) - 1);
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  function automatic logic [30:0] rnd_area();
    int          sel;
    logic [30:0] v;
    sel = $urandom_range(99);
    if (sel < 5) v = '0;
    else if (sel < 8) v = 31'd1;
    else if (sel < 18) v = 31'($urandom);
    else v = 31'($urandom_range(1 << 19, 1 << 12));
    return v;
  endfunction

  function automatic logic [30:0] rnd_dt();
    int          sel;
    logic [30:0] v;
    sel = $urandom_range(99);
    if (sel < 5) v = '0;
    else if (sel < 15) v = 31'($urandom);
    else v = 31'($urandom_range(1 << 16, 1 << 8));
    return v;
  endfunction

  function automatic tick_t rnd_tick();
    tick_t t;
    t.act   = ($urandom_range(99) < 6) ? ACT_RESET : ACT_TICK;
    t.cur   = rnd_val(20);
    t.area  = rnd_area();
    t.dt    = rnd_dt();
    t.patch = rnd_val(20);
    t.rdrv  = rnd_val(20);
    return t;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_cnt);
    n_err++;
  endtask

  // request side, entered and left at a falling edge
  task automatic send_item(input tick_t t, input bit known, input result_t want);
    result_t r;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= t.act;
    s_tdata  <= {2'b00, t.rdrv, t.patch, t.dt, t.area, t.cur};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = regulate_step(t);
    pending_results.push_back(known ? want : r);
    n_req++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    apply_reg(idx, val);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_setting();
    int    sel;
    data_t lo, hi;
    write_reg(REG_FLAGS, $urandom_range(3));
    write_reg(REG_GOAL, rnd_val(18));
    write_reg(REG_PROP_GAIN, rnd_val(17));
    write_reg(REG_INT_GAIN, rnd_val(16));
    sel = $urandom_range(99);
    if (sel < 10) write_reg(REG_STEP_LIM, {1'b0, 31'($urandom)});
    else if (sel < 15) write_reg(REG_STEP_LIM, '0);
    else write_reg(REG_STEP_LIM, $urandom_range(1 << 18));
    sel = $urandom_range(99);
    if (sel < 10) begin
      lo = $urandom;
      hi = $urandom;
    end else if (sel < 20) begin
      lo = DATA_MIN;
      hi = DATA_MAX;
    end else begin
      lo = -data_t'($urandom_range(1 << 22));
      hi = $urandom_range(1 << 22);
    end
    write_reg(REG_DRIVE_MIN, lo);
    write_reg(REG_DRIVE_MAX, hi);
    sel = $urandom_range(99);
    if (sel < 10) write_reg(REG_PERIOD, '0);
    else if (sel < 80) write_reg(REG_PERIOD, $urandom_range(4, 1));
    else write_reg(REG_PERIOD, $urandom_range(24, 5));
    n_settings++;
  endtask

  // result side: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (m_tuser) n_upd++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", m_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[31:0] !== want.drv) report_mismatch("drive_value", m_tdata[31:0], want.drv);
        if (m_tuser !== want.upd)
          report_mismatch("did_update", 32'(m_tuser), 32'(want.upd));
        if (m_tdata[63:32] !== want.err) report_mismatch("error_value", m_tdata[63:32], want.err);
        if (m_tdata[95:64] !== want.integ)
          report_mismatch("integral_value", m_tdata[95:64], want.integ);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    row_t    r;
    result_t none;
    none = res('0, 1'b0, '0, '0);
    regs_to_reset();

    // defaults: drive loaded from patch average, zero gains
    add_known(mk(ACT_TICK, -5 * ONE, 31'h1_0000, '0, 3 * ONE, '0),
              res(3 * ONE, 1'b1, -5 * ONE, '0));
    // most negative current, zero area: integral and drive untouched
    add_known(mk(ACT_TICK, DATA_MIN, '0, 31'h1_0000, 7 * ONE, '0),
              res(3 * ONE, 1'b1, 32'sh8000_0001, '0));
    add_known(mk(ACT_RESET, '0, '0, '0, '0, DATA_MAX), res(DATA_MAX, 1'b0, '0, '0));
    add_known(mk(ACT_RESET, '0, '0, '0, '0, DATA_MIN), res(DATA_MIN, 1'b0, '0, '0));
    // average mode, period zero acts as one
    add_reg(REG_FLAGS, 32'd1);
    add_reg(REG_GOAL, 2 * ONE);
    add_reg(REG_PROP_GAIN, 32'h0000_8000);
    add_reg(REG_INT_GAIN, 32'h0000_4000);
    add_reg(REG_STEP_LIM, ONE);
    add_reg(REG_PERIOD, 32'd0);
    // pinned at the lower limit with negative error
    add_req(mk(ACT_TICK, 8 * ONE, 31'h2_0000, 31'd6554, '0, '0));
    add_req(mk(ACT_TICK, -3 * ONE, '0, 31'h1_0000, '0, '0));
    add_req(mk(ACT_TICK, DATA_MAX, 31'd1, 31'h7FFF_FFFF, '0, '0));
    add_req(mk(ACT_TICK, ONE, 31'h7FFF_FFFF, 31'h1_0000, '0, '0));
    // crossed limits
    add_reg(REG_DRIVE_MIN, ONE);
    add_reg(REG_DRIVE_MAX, -ONE);
    add_req(mk(ACT_TICK, ONE, 31'h1_0000, 31'h1_0000, '0, '0));
    // pinned at the upper limit with positive error
    add_reg(REG_DRIVE_MIN, DATA_MIN);
    add_reg(REG_DRIVE_MAX, 5 * ONE);
    add_req(mk(ACT_RESET, '0, '0, '0, '0, 9 * ONE));
    add_req(mk(ACT_TICK, '0, 31'h1_0000, 31'h1_0000, '0, '0));
    // cadence of three with one-time load
    add_reg(REG_FLAGS, 32'd3);
    add_reg(REG_PERIOD, 32'd3);
    add_req(mk(ACT_RESET, '0, '0, '0, '0, '0));
    add_req(mk(ACT_TICK, ONE, 31'h1_0000, 31'h1_0000, 2 * ONE, '0));
    add_req(mk(ACT_TICK, ONE, 31'h1_0000, 31'h1_0000, -2 * ONE, '0));
    add_req(mk(ACT_TICK, ONE, 31'h1_0000, 31'h1_0000, -2 * ONE, '0));
    add_req(mk(ACT_TICK, -ONE, 31'h1_0000, 31'h1_0000, -2 * ONE, '0));
    // every register at its top but the lower drive limit
    add_reg(REG_GOAL, DATA_MAX);
    add_reg(REG_PROP_GAIN, DATA_MAX);
    add_reg(REG_INT_GAIN, DATA_MAX);
    add_reg(REG_STEP_LIM, 32'h7FFF_FFFF);
    add_reg(REG_DRIVE_MAX, DATA_MAX);
    add_reg(REG_PERIOD, 32'hFFFF);
    add_req(mk(ACT_RESET, '0, '0, '0, '0, '0));
    add_req(mk(ACT_TICK, DATA_MAX, 31'h7FFF_FFFF, 31'h7FFF_FFFF, DATA_MAX, '0));
    add_req(mk(ACT_TICK, DATA_MIN, 31'd1, 31'h7FFF_FFFF, DATA_MIN, '0));
    // every register at its bottom but the lower drive limit, which is at its top
    add_reg(REG_FLAGS, 32'd0);
    add_reg(REG_GOAL, DATA_MIN);
    add_reg(REG_PROP_GAIN, DATA_MIN);
    add_reg(REG_INT_GAIN, DATA_MIN);
    add_reg(REG_STEP_LIM, 32'd0);
    add_reg(REG_DRIVE_MIN, DATA_MAX);
    add_reg(REG_DRIVE_MAX, DATA_MIN);
    add_reg(REG_PERIOD, 32'd0);
    add_req(mk(ACT_TICK, DATA_MAX, 31'h7FFF_FFFF, 31'h7FFF_FFFF, '0, '0));
    add_req(mk(ACT_TICK, DATA_MIN, '0, '0, '0, '0));
    // ordinary total mode
    add_reg(REG_GOAL, ONE);
    add_reg(REG_PROP_GAIN, 32'h0000_2000);
    add_reg(REG_INT_GAIN, 32'h0000_1000);
    add_reg(REG_STEP_LIM, 32'd6554);
    add_reg(REG_DRIVE_MIN, -4 * ONE);
    add_reg(REG_DRIVE_MAX, 4 * ONE);
    add_reg(REG_PERIOD, 32'd2);
    add_req(mk(ACT_RESET, '0, '0, '0, '0, '0));
    add_req(mk(ACT_TICK, 3 * ONE, 31'h2_0000, 31'h0000_4000, '0, '0));
    add_req(mk(ACT_TICK, -ONE, 31'h2_0000, 31'h0000_4000, '0, '0));
    add_req(mk(ACT_TICK, ONE, 31'h1_0000, 31'h0000_4000, '0, '0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 29;
    recv_idle = 77;
    n_settings = 1;
    foreach (stim_table[k]) begin
      r = stim_table[k];
      if (r.kind == ROW_REG) begin
        wait_idle();
        write_reg(r.idx, r.val);
      end else begin
        send_item(r.req, r.known, r.want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 29 : (ph == 1) ? 77 : 0;
      recv_idle = (ph == 0) ? 77 : (ph == 1) ? 29 : 0;
      for (int s = 0; s < 6; s++) begin
        wait_idle();
        random_setting();
        for (int i = 0; i < 97; i++) begin
          // long hold-off on the result side while requests keep coming
          if (ph == 2 && s == 0 && i == 10) stall_left = 500;
          // sender pause until everything is back
          if (ph == 2 && s == 1 && i == 40) wait_idle();
          send_item(rnd_tick(), 0, none);
        end
      end
    end

    wait_idle();
    repeat (80) @(negedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never arrived", pending_results.size(), '0);

    $display("covered %0d requests over %0d register settings, %0d updates returned",
             n_req, n_settings + 7, n_upd);
    $display("both streams stalled at random, with one long result hold-off; %0d mismatches",
             n_err);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
